// ===== rtl/cpq_pkg.sv =====
// ----------------------------------------------------------------------------
// cpq_pkg
// Shared types, constants and helper functions of the cell palette quantiser.
// ----------------------------------------------------------------------------
package cpq_pkg;

    // sizes fixed by the field widths
    localparam int PALETTE_SIZE = 16;
    localparam int POS_W        = 17;
    localparam int ORG_W        = 16;
    localparam int DIM_W        = 9;
    localparam int CNT_W        = 8;
    localparam int GLYPH_W      = 16;
    localparam int CHAN_W       = 8;
    localparam int IDX_W        = 4;
    localparam int SQ_W         = 16;
    localparam int DIST_W       = 18;
    localparam int LEVELS       = 4;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [DIM_W-1:0]  MAX_LAYER_WIDTH   = 9'd256;
    localparam logic [DIM_W-1:0]  MAX_LAYER_HEIGHT  = 9'd256;
    localparam logic [DIM_W-1:0]  RESET_WIDTH       = 9'd80;
    localparam logic [DIM_W-1:0]  RESET_HEIGHT      = 9'd25;
    localparam logic [CHAN_W-1:0] TRANSPARENT_LEVEL = 8'd255;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ORIGIN_X     = 2'd0,
        CFG_ORIGIN_Y     = 2'd1,
        CFG_LAYER_WIDTH  = 2'd2,
        CFG_LAYER_HEIGHT = 2'd3
    } t_cfg_reg;

    // the palette uses only four levels per channel
    localparam logic [CHAN_W-1:0] LEVEL_VALUE [LEVELS] = '{8'd0, 8'd84, 8'd168, 8'd252};

    // level code of each palette entry per channel
    localparam logic [1:0] PAL_RED_CODE [PALETTE_SIZE] =
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2,
          2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3, 2'd3};
    localparam logic [1:0] PAL_GREEN_CODE [PALETTE_SIZE] =
        '{2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd2,
          2'd1, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1, 2'd3, 2'd3};
    localparam logic [1:0] PAL_BLUE_CODE [PALETTE_SIZE] =
        '{2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2,
          2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3};

    typedef logic [SQ_W-1:0]   t_sq;
    typedef logic [DIST_W-1:0] t_dist;

    // non-empty cell as it travels through the queue
    typedef struct packed {
        logic signed [POS_W-1:0] screen_x;
        logic signed [POS_W-1:0] screen_y;
        logic [GLYPH_W-1:0]      glyph;
        logic [CHAN_W-1:0]       fg_red;
        logic [CHAN_W-1:0]       fg_green;
        logic [CHAN_W-1:0]       fg_blue;
        logic [CHAN_W-1:0]       back_red;
        logic [CHAN_W-1:0]       back_green;
        logic [CHAN_W-1:0]       back_blue;
    } t_cell;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // square of the distance between a level and a palette level
    function automatic t_sq sq_diff(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return t_sq'(d) * t_sq'(d);
    endfunction

    // lowest of four distances, lowest position wins a tie
    function automatic logic [1:0] min4_pos(input t_dist [3:0] d);
        logic [1:0] best;
        t_dist      best_d;
        best   = 2'd0;
        best_d = d[0];
        for (int k = 1; k < 4; k++) begin
            if (d[k] < best_d) begin
                best   = 2'(k);
                best_d = d[k];
            end
        end
        return best;
    endfunction

endpackage

// ===== rtl/cpq_front.sv =====
// ----------------------------------------------------------------------------
// cpq_front
// Configuration registers, layer position counters and empty-cell filter.
// ----------------------------------------------------------------------------
module cpq_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cpq_pkg::GLYPH_W-1:0]     i_glyph,
    input  logic [cpq_pkg::CHAN_W-1:0]      i_fg_red,
    input  logic [cpq_pkg::CHAN_W-1:0]      i_fg_green,
    input  logic [cpq_pkg::CHAN_W-1:0]      i_fg_blue,
    input  logic [cpq_pkg::CHAN_W-1:0]      i_back_red,
    input  logic [cpq_pkg::CHAN_W-1:0]      i_back_green,
    input  logic [cpq_pkg::CHAN_W-1:0]      i_back_blue,
    input  cpq_pkg::t_q_stat                i_q_stat,
    output logic                            o_push,
    output cpq_pkg::t_cell                  o_cell
);
    import cpq_pkg::*;

    logic signed [ORG_W-1:0] r_origin_x, r_origin_y;
    logic [DIM_W-1:0]        r_width, r_height;
    logic [CNT_W-1:0]        r_col, r_row;
    logic [CNT_W-1:0]        n_col, n_row;
    logic [DIM_W-1:0]        w_lim, h_lim;
    logic                    accept;

    // usable limit: zero acts as one, oversize clamps
    function automatic logic [DIM_W-1:0] limit_of(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)       r = DIM_W'(1);
        else if (v > maxv) r = maxv;
        else               r = v;
        return r;
    endfunction

    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_width    <= RESET_WIDTH;
            r_height   <= RESET_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ORIGIN_X:     r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y:     r_origin_y <= i_cfg_data;
                CFG_LAYER_WIDTH:  r_width    <= i_cfg_data[DIM_W-1:0];
                CFG_LAYER_HEIGHT: r_height   <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;

    // counter advance, wraps at the limits
    always_comb begin
        w_lim = limit_of(r_width, MAX_LAYER_WIDTH);
        h_lim = limit_of(r_height, MAX_LAYER_HEIGHT);
        n_col = r_col;
        n_row = r_row;
        if ({1'b0, r_col} + DIM_W'(1) >= w_lim) begin
            n_col = '0;
            if ({1'b0, r_row} + DIM_W'(1) >= h_lim) n_row = '0;
            else                                    n_row = r_row + CNT_W'(1);
        end else begin
            n_col = r_col + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // queue entry for non-empty cells
    assign o_push = accept && (i_glyph != '0);

    always_comb begin
        o_cell.screen_x   = {r_origin_x[ORG_W-1], r_origin_x} + POS_W'({1'b0, r_col});
        o_cell.screen_y   = {r_origin_y[ORG_W-1], r_origin_y} + POS_W'({1'b0, r_row});
        o_cell.glyph      = i_glyph;
        o_cell.fg_red     = i_fg_red;
        o_cell.fg_green   = i_fg_green;
        o_cell.fg_blue    = i_fg_blue;
        o_cell.back_red   = i_back_red;
        o_cell.back_green = i_back_green;
        o_cell.back_blue  = i_back_blue;
    end

endmodule

// ===== rtl/cpq_queue.sv =====
// ----------------------------------------------------------------------------
// cpq_queue
// Short register queue between the cell front end and the palette search.
// ----------------------------------------------------------------------------
module cpq_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cpq_pkg::t_cell   i_cell,
    input  logic             i_pop,
    output cpq_pkg::t_cell   o_cell,
    output cpq_pkg::t_q_stat o_stat
);
    import cpq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cell              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_count;
    logic               do_push, do_pop;

    assign o_stat.full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cell       = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cell;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= r_rd + PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/cpq_back.sv =====
// ----------------------------------------------------------------------------
// cpq_back
// Pipelined nearest-colour search for foreground and background.
// ----------------------------------------------------------------------------
module cpq_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cpq_pkg::t_cell                      i_cell,
    input  cpq_pkg::t_q_stat                    i_q_stat,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [cpq_pkg::POS_W-1:0]    o_screen_x,
    output logic signed [cpq_pkg::POS_W-1:0]    o_screen_y,
    output logic [cpq_pkg::GLYPH_W-1:0]         o_glyph_out,
    output logic [cpq_pkg::IDX_W-1:0]           o_fg_index,
    output logic [cpq_pkg::IDX_W-1:0]           o_bg_index
);
    import cpq_pkg::*;

    // cell data carried alongside the search
    typedef struct packed {
        logic signed [POS_W-1:0] screen_x;
        logic signed [POS_W-1:0] screen_y;
        logic [GLYPH_W-1:0]      glyph;
        logic                    transparent;
    } t_tag;

    logic                       en;
    logic                       r_v1, r_v2, r_v3, r_v4;
    t_tag                       r_t1, r_t2, r_t3;
    t_tag                       n_t1;
    t_sq   [1:0][2:0][3:0]      r_sq, n_sq;
    t_dist [1:0][15:0]          r_dist, n_dist;
    t_dist [1:0][3:0]           r_gdist, n_gdist;
    logic  [1:0][3:0][1:0]      r_gpos, n_gpos;
    logic  [IDX_W-1:0]          n_idx [2];
    logic  [1:0]                grp;

    // whole pipeline moves unless the output register is held
    assign en    = !r_v4 || !i_out_stall;
    assign o_pop = en && !i_q_stat.empty;

    // stage one: squared level differences per channel
    always_comb begin
        logic [CHAN_W-1:0] ch [2][3];
        ch[0][0] = i_cell.fg_red;
        ch[0][1] = i_cell.fg_green;
        ch[0][2] = i_cell.fg_blue;
        ch[1][0] = i_cell.back_red;
        ch[1][1] = i_cell.back_green;
        ch[1][2] = i_cell.back_blue;
        for (int s = 0; s < 2; s++)
            for (int c = 0; c < 3; c++)
                for (int l = 0; l < LEVELS; l++)
                    n_sq[s][c][l] = sq_diff(ch[s][c], LEVEL_VALUE[l]);
        n_t1.screen_x    = i_cell.screen_x;
        n_t1.screen_y    = i_cell.screen_y;
        n_t1.glyph       = i_cell.glyph;
        n_t1.transparent = (i_cell.back_red == TRANSPARENT_LEVEL) &&
                           (i_cell.back_green == '0) &&
                           (i_cell.back_blue == TRANSPARENT_LEVEL);
    end

    // stage two: distance to each palette entry
    always_comb begin
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < PALETTE_SIZE; i++)
                n_dist[s][i] = DIST_W'(r_sq[s][0][PAL_RED_CODE[i]]) +
                               DIST_W'(r_sq[s][1][PAL_GREEN_CODE[i]]) +
                               DIST_W'(r_sq[s][2][PAL_BLUE_CODE[i]]);
    end

    // stage three: minimum within each group of four entries
    always_comb begin
        for (int s = 0; s < 2; s++)
            for (int g = 0; g < 4; g++) begin
                n_gpos[s][g]  = min4_pos(r_dist[s][g*4 +: 4]);
                n_gdist[s][g] = r_dist[s][g*4 + int'(n_gpos[s][g])];
            end
    end

    // stage four: minimum across groups
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            grp      = min4_pos(r_gdist[s]);
            n_idx[s] = {grp, r_gpos[s][grp]};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= !i_q_stat.empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq        <= n_sq;
            r_t1        <= n_t1;
            r_dist      <= r_v1 ? n_dist : r_dist;
            r_t2        <= r_t1;
            r_gdist     <= n_gdist;
            r_gpos      <= n_gpos;
            r_t3        <= r_t2;
            o_screen_x  <= r_t3.screen_x;
            o_screen_y  <= r_t3.screen_y;
            o_glyph_out <= r_t3.glyph;
            o_fg_index  <= n_idx[0];
            o_bg_index  <= r_t3.transparent ? '0 : n_idx[1];
        end
    end

    assign o_out_valid = r_v4;

endmodule

// ===== rtl/cell_palette_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// cell_palette_quantizer_top
// Maps layer cells to screen positions and 16-colour palette indexes.
// ----------------------------------------------------------------------------
// Takes one cell per clock unless the queue is full and, at full flow,
// delivers one result per clock. Empty cells (glyph zero) advance the layer
// counters but give no result. A non-empty cell passes a four-entry queue
// and then a four-stage palette search (level squares, entry distances,
// group minimum, final minimum with the output register). A stall on the
// result side holds the search pipeline; the queue keeps taking cells until
// it is full. Configuration writes are always ready and take effect on the
// next cell.
// ----------------------------------------------------------------------------
module cell_palette_quantizer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [cpq_pkg::GLYPH_W-1:0]         i_glyph,
    input  logic [cpq_pkg::CHAN_W-1:0]          i_fg_red,
    input  logic [cpq_pkg::CHAN_W-1:0]          i_fg_green,
    input  logic [cpq_pkg::CHAN_W-1:0]          i_fg_blue,
    input  logic [cpq_pkg::CHAN_W-1:0]          i_back_red,
    input  logic [cpq_pkg::CHAN_W-1:0]          i_back_green,
    input  logic [cpq_pkg::CHAN_W-1:0]          i_back_blue,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [cpq_pkg::POS_W-1:0]    o_screen_x,
    output logic signed [cpq_pkg::POS_W-1:0]    o_screen_y,
    output logic [cpq_pkg::GLYPH_W-1:0]         o_glyph_out,
    output logic [cpq_pkg::IDX_W-1:0]           o_fg_index,
    output logic [cpq_pkg::IDX_W-1:0]           o_bg_index
);
    import cpq_pkg::*;

    t_cell   push_cell, pop_cell;
    t_q_stat q_stat;
    logic    push, pop;

    // cell intake and position counters
    cpq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_glyph      (i_glyph),
        .i_fg_red     (i_fg_red),
        .i_fg_green   (i_fg_green),
        .i_fg_blue    (i_fg_blue),
        .i_back_red   (i_back_red),
        .i_back_green (i_back_green),
        .i_back_blue  (i_back_blue),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_cell       (push_cell)
    );

    // decoupling queue
    cpq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (push_cell),
        .i_pop   (pop),
        .o_cell  (pop_cell),
        .o_stat  (q_stat)
    );

    // palette search and result register
    cpq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell      (pop_cell),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_screen_x  (o_screen_x),
        .o_screen_y  (o_screen_y),
        .o_glyph_out (o_glyph_out),
        .o_fg_index  (o_fg_index),
        .o_bg_index  (o_bg_index)
    );

endmodule
